/* hw/rtl/kvs_pkg.sv */
// Shared types and codes of the key/value table.
`timescale 1ns / 1ps
package kvs_pkg;

  localparam int unsigned KeyW = 32;
  localparam int unsigned ValW = 32;

  typedef enum logic [1:0] {
    FN_LOOKUP = 2'd0,
    FN_STORE  = 2'd1,
    FN_DELETE = 2'd2
  } func_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  // One entry as read back from the table.
  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } entry_t;

  // Write controls from the sequencer to the table.
  typedef struct packed {
    logic en;
    logic valid;
    logic key_en;
    logic value_en;
  } wr_ctl_t;

  // Result word handed to the output register.
  typedef struct packed {
    status_e         status;
    logic [ValW-1:0] value;
  } resp_t;

endpackage

/* hw/rtl/kvs_table.sv */
// Entry storage: valid marks, keys and values, one write port and one registered read port.
`timescale 1ns / 1ps
module kvs_table #(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                   clk_i,
  input  logic [IW-1:0]          wr_addr_i,
  input  kvs_pkg::wr_ctl_t       wr_ctl_i,
  input  logic [kvs_pkg::KeyW-1:0] wr_key_i,
  input  logic [kvs_pkg::ValW-1:0] wr_value_i,
  input  logic [IW-1:0]          rd_addr_i,
  output kvs_pkg::entry_t        rd_data_o
);
  import kvs_pkg::*;

  logic            valid_mem [ENTRIES];
  logic [KeyW-1:0] key_mem   [ENTRIES];
  logic [ValW-1:0] value_mem [ENTRIES];

  always_ff @(posedge clk_i) begin
    if (wr_ctl_i.en) begin
      valid_mem[wr_addr_i] <= wr_ctl_i.valid;
      if (wr_ctl_i.key_en) begin
        key_mem[wr_addr_i] <= wr_key_i;
      end
      if (wr_ctl_i.value_en) begin
        value_mem[wr_addr_i] <= wr_value_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_o.valid <= valid_mem[rd_addr_i];
    rd_data_o.key   <= key_mem[rd_addr_i];
    rd_data_o.value <= value_mem[rd_addr_i];
  end

endmodule

/* hw/rtl/kvs_seq.sv */
// Sequencer: clearing pass, linear key scan through one shared comparator, table update.
`timescale 1ns / 1ps
module kvs_seq #(
  parameter int unsigned ENTRIES = 16,
  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [1:0]               func_i,
  input  logic [kvs_pkg::KeyW-1:0] key_i,
  input  logic [kvs_pkg::ValW-1:0] value_i,
  output logic                     resp_valid_o,
  input  logic                     resp_ready_i,
  output kvs_pkg::resp_t           resp_o,
  output logic [IW-1:0]            wr_addr_o,
  output kvs_pkg::wr_ctl_t         wr_ctl_o,
  output logic [kvs_pkg::KeyW-1:0] wr_key_o,
  output logic [kvs_pkg::ValW-1:0] wr_value_o,
  output logic [IW-1:0]            rd_addr_o,
  input  kvs_pkg::entry_t          rd_data_i
);
  import kvs_pkg::*;

  localparam logic [IW-1:0] Last = IW'(ENTRIES - 1);

  typedef enum logic [3:0] {
    S_CLEAR = 4'b0001,
    S_IDLE  = 4'b0010,
    S_SCAN  = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e          state_q, state_d;
  logic [IW-1:0]   idx_q, idx_d;
  logic            issue_done_q, issue_done_d;
  logic            rd_pend_q, rd_pend_d;
  logic [IW-1:0]   rd_idx_q, rd_idx_d;
  logic            hit_q, hit_d;
  logic [IW-1:0]   hit_idx_q, hit_idx_d;
  logic [ValW-1:0] hit_val_q, hit_val_d;
  logic            free_q, free_d;
  logic [IW-1:0]   free_idx_q, free_idx_d;
  func_e           func_q, func_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] value_q, value_d;
  logic            key_match;

  // The one shared comparator
  assign key_match = rd_data_i.valid && (rd_data_i.key == key_q);

  assign in_ready_o = (state_q == S_IDLE);
  assign rd_addr_o  = idx_q;
  assign wr_key_o   = key_q;
  assign wr_value_o = value_q;

  always_comb begin
    state_d      = state_q;
    idx_d        = idx_q;
    issue_done_d = issue_done_q;
    rd_pend_d    = 1'b0;
    rd_idx_d     = rd_idx_q;
    hit_d        = hit_q;
    hit_idx_d    = hit_idx_q;
    hit_val_d    = hit_val_q;
    free_d       = free_q;
    free_idx_d   = free_idx_q;
    func_d       = func_q;
    key_d        = key_q;
    value_d      = value_q;
    wr_addr_o    = idx_q;
    wr_ctl_o     = '0;
    resp_valid_o = 1'b0;
    resp_o.status = ST_NOT_FOUND;
    resp_o.value  = '0;

    case (state_q)
      S_CLEAR: begin
        wr_ctl_o.en = 1'b1;
        if (idx_q == Last) begin
          idx_d   = '0;
          state_d = S_IDLE;
        end else begin
          idx_d = idx_q + IW'(1);
        end
      end

      S_IDLE: begin
        if (in_valid_i) begin
          func_d       = func_e'(func_i);
          key_d        = key_i;
          value_d      = value_i;
          idx_d        = '0;
          issue_done_d = 1'b0;
          hit_d        = 1'b0;
          free_d       = 1'b0;
          state_d      = S_SCAN;
        end
      end

      S_SCAN: begin
        // issue the next read while the previous entry is compared
        if (!issue_done_q) begin
          rd_pend_d = 1'b1;
          rd_idx_d  = idx_q;
          if (idx_q == Last) begin
            issue_done_d = 1'b1;
          end else begin
            idx_d = idx_q + IW'(1);
          end
        end
        if (rd_pend_q) begin
          if (key_match) begin
            hit_d     = 1'b1;
            hit_idx_d = rd_idx_q;
            hit_val_d = rd_data_i.value;
            rd_pend_d = 1'b0;
            state_d   = S_DONE;
          end else begin
            if (!rd_data_i.valid && !free_q) begin
              free_d     = 1'b1;
              free_idx_d = rd_idx_q;
            end
            if (rd_idx_q == Last) begin
              rd_pend_d = 1'b0;
              state_d   = S_DONE;
            end
          end
        end
      end

      S_DONE: begin
        resp_valid_o = 1'b1;
        wr_addr_o    = hit_q ? hit_idx_q : free_idx_q;
        case (func_q)
          FN_LOOKUP: begin
            if (hit_q) begin
              resp_o.status = ST_OK;
              resp_o.value  = hit_val_q;
            end
          end
          FN_STORE: begin
            if (hit_q || free_q) begin
              wr_ctl_o.en       = resp_ready_i;
              wr_ctl_o.valid    = 1'b1;
              wr_ctl_o.key_en   = !hit_q;
              wr_ctl_o.value_en = 1'b1;
              resp_o.status     = ST_OK;
              resp_o.value      = value_q;
            end else begin
              resp_o.status = ST_FULL;
            end
          end
          FN_DELETE: begin
            if (hit_q) begin
              wr_ctl_o.en   = resp_ready_i;
              resp_o.status = ST_OK;
              resp_o.value  = hit_val_q;
            end
          end
          default: begin
            resp_o.status = ST_NOT_FOUND;
          end
        endcase
        // hold until the output register can take the word
        if (resp_ready_i) begin
          state_d = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_CLEAR;
      idx_q        <= '0;
      issue_done_q <= 1'b0;
      rd_pend_q    <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
    end else begin
      state_q      <= state_d;
      idx_q        <= idx_d;
      issue_done_q <= issue_done_d;
      rd_pend_q    <= rd_pend_d;
      hit_q        <= hit_d;
      free_q       <= free_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_idx_q   <= rd_idx_d;
    hit_idx_q  <= hit_idx_d;
    hit_val_q  <= hit_val_d;
    free_idx_q <= free_idx_d;
    func_q     <= func_d;
    key_q      <= key_d;
    value_q    <= value_d;
  end

  a_wr_only_clear_or_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_ctl_o.en |-> (state_q == S_CLEAR) || (state_q == S_DONE))
    else $error("table written outside clearing pass or update step");

  a_fail_zero_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && (resp_o.status != ST_OK) |-> (resp_o.value == '0))
    else $error("non-zero value with a failing status");

  a_full_only_on_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    resp_valid_o && (resp_o.status == ST_FULL) |-> (func_q == FN_STORE) && !hit_q && !free_q)
    else $error("full reported without a store into a full table");

  a_scan_ends_in_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_SCAN) && rd_pend_q && key_match |=> (state_q == S_DONE) && hit_q)
    else $error("key match did not end the scan");

endmodule

/* hw/rtl/key_value_store.sv */
// Top level of the key/value table: sequencer, entry storage and output register.
`timescale 1ns / 1ps
// Associative table of ENTRIES 32-bit keys with 32-bit values. func_i selects lookup, store
// (insert or update) or delete; each word gives one result with status_o and result_value_o.
// Entries are scanned in order through a single key comparator fed by the one read port of
// the entry memory, one entry per cycle; the scan ends early when the key is found. Inserts
// take the lowest free entry. After reset the block clears the valid marks of all entries
// before in_ready_o first rises. A finished result sits in the output register, so the next
// word is taken while it waits.
module key_value_store #(
  parameter int unsigned ENTRIES = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [1:0]  func_i,
  input  logic [31:0] key_i,
  input  logic [31:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [1:0]  status_o,
  output logic [31:0] result_value_o
);
  import kvs_pkg::*;

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;

  logic            resp_valid, resp_ready;
  resp_t           resp;
  logic [IW-1:0]   wr_addr, rd_addr;
  wr_ctl_t         wr_ctl;
  logic [KeyW-1:0] wr_key;
  logic [ValW-1:0] wr_value;
  entry_t          rd_data;
  logic            out_valid_q, out_valid_d;
  resp_t           out_q;

  kvs_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk_i,
    .rst_ni,
    .in_valid_i,
    .in_ready_o,
    .func_i,
    .key_i,
    .value_i,
    .resp_valid_o (resp_valid),
    .resp_ready_i (resp_ready),
    .resp_o       (resp),
    .wr_addr_o    (wr_addr),
    .wr_ctl_o     (wr_ctl),
    .wr_key_o     (wr_key),
    .wr_value_o   (wr_value),
    .rd_addr_o    (rd_addr),
    .rd_data_i    (rd_data)
  );

  kvs_table #(.ENTRIES(ENTRIES)) u_table (
    .clk_i,
    .wr_addr_i  (wr_addr),
    .wr_ctl_i   (wr_ctl),
    .wr_key_i   (wr_key),
    .wr_value_i (wr_value),
    .rd_addr_i  (rd_addr),
    .rd_data_o  (rd_data)
  );

  // output register: load when empty or being drained
  assign resp_ready  = !out_valid_q || out_ready_i;
  assign out_valid_d = (resp_valid && resp_ready) || (out_valid_q && !out_ready_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (resp_valid && resp_ready) begin
      out_q <= resp;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign status_o       = out_q.status;
  assign result_value_o = out_q.value;

endmodule
